>>> rtl/core/pidad_pkg.sv
package pidad_pkg;

	localparam int AvgDepthDefault = 10;
	localparam int CfgIdxW = 3;

	localparam logic [CfgIdxW-1:0] REG_KP   = 3'd0;
	localparam logic [CfgIdxW-1:0] REG_KI   = 3'd1;
	localparam logic [CfgIdxW-1:0] REG_KD   = 3'd2;
	localparam logic [CfgIdxW-1:0] REG_MAX  = 3'd3;
	localparam logic [CfgIdxW-1:0] REG_MIN  = 3'd4;

	localparam logic [15:0] KP_RESET  = 16'd3867;
	localparam logic [15:0] KI_RESET  = 16'd3277;
	localparam logic [15:0] KD_RESET  = 16'd2294;
	localparam logic [15:0] MAX_RESET = 16'h7fff;
	localparam logic [15:0] MIN_RESET = 16'h8000;

	typedef struct packed {
		logic signed [15:0] measurement;
		logic signed [15:0] target;
		logic [15:0]        elapsed;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] drive;
		logic signed [31:0] p_term;
		logic signed [31:0] i_term;
		logic signed [31:0] d_term;
	} out_item_t;

	// start and sign request for the serial divider
	typedef struct packed {
		logic start;
		logic neg;
	} div_ctl_t;

endpackage

>>> rtl/core/pidad_div.sv
// Restoring divider, one quotient bit per cycle.
// Magnitudes: 48-bit dividend by 16-bit divisor, truncated quotient with sign applied.
module pidad_div (
	input  logic                  clk,
	input  logic                  arst_n,
	input  pidad_pkg::div_ctl_t   ctl,
	input  logic [47:0]           dividend,
	input  logic [15:0]           divisor,
	output logic                  done,
	output logic signed [48:0]    quotient
);

	logic [47:0] quo_q;
	logic [16:0] rem_q;
	logic [15:0] dvs_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic        neg_q;
	logic [16:0] trial;
	logic [16:0] shifted;

	assign shifted = {rem_q[15:0], quo_q[47]};
	assign trial   = shifted - {1'b0, dvs_q};

	// one bit per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (ctl.start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'd47;
			end else if (busy_q) begin
				if (cnt_q == 6'd0) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
				cnt_q <= cnt_q - 6'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
			neg_q <= ctl.neg;
		end else if (busy_q) begin
			if (!trial[16]) begin
				rem_q <= trial;
				quo_q <= {quo_q[46:0], 1'b1};
			end else begin
				rem_q <= shifted;
				quo_q <= {quo_q[46:0], 1'b0};
			end
		end
	end

	assign quotient = neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});

`ifndef SYNTHESIS
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("divider done held");
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.start |=> busy_q) else $error("divider did not start");
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy_q)) else $error("done without work");
`endif

endmodule

>>> rtl/core/pid_with_averaged_derivative_unit.sv
// Channel | dir | handshake            | payload
// in      | in  | in_valid / in_stall  | in_data  (measurement, target, elapsed)
// out     | out | out_valid / out_stall| out_data (drive, p_term, i_term, d_term)
// cfg     | in  | cfg_we               | cfg_index, cfg_data
// An item holds the block from its input transfer until its result is taken; no new item
// is accepted meanwhile. In order it passes the multiply, the serial divider, the ring walk
// over AVG_DEPTH entries, a step to close the sum, the mean and the result register with
// the handshakes. The first item and a zero elapsed skip the divider.
// in_stall is high from acceptance until the result register is free again.
// A held out_stall keeps the result; the next item waits for it.
// Reset clears gains to defaults, the ring valid bits, the slot and the start flag.
module pid_with_averaged_derivative_unit #(
	parameter int AVG_DEPTH = pidad_pkg::AvgDepthDefault
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  pidad_pkg::in_item_t  in_data,
	output logic                 out_valid,
	input  logic                 out_stall,
	output pidad_pkg::out_item_t out_data,
	input  logic                 cfg_we,
	input  logic [pidad_pkg::CfgIdxW-1:0] cfg_index,
	input  logic [15:0]          cfg_data
);

	localparam int SlotW = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;
	localparam logic [SlotW-1:0] LastSlot = SlotW'(AVG_DEPTH - 1);

	// reciprocal of the depth, rounded up, scaled by 2^44
	localparam int RecipShift = 44;
	localparam longint unsigned RecipFull =
		((64'd1 << RecipShift) + 64'(AVG_DEPTH) - 64'd1) / 64'(AVG_DEPTH);
	localparam logic [47:0] Recip = 48'(RecipFull);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_MUL  = 3'd1;
	localparam logic [2:0] ST_DIV  = 3'd2;
	localparam logic [2:0] ST_SUM  = 3'd3;
	localparam logic [2:0] ST_ACC  = 3'd4;
	localparam logic [2:0] ST_MEAN = 3'd5;
	localparam logic [2:0] ST_FIN  = 3'd6;
	localparam logic [2:0] ST_OUT  = 3'd7;

	logic [2:0] state_q;
	logic [15:0] kp_q, ki_q, kd_q, max_q, min_q;
	logic signed [15:0] prev_q;
	logic signed [31:0] integ_q;
	logic started_q;
	logic [SlotW-1:0] slot_q, idx_q;
	logic signed [31:0] ring_q [AVG_DEPTH];
	logic [AVG_DEPTH-1:0] ring_vld_q;

	pidad_pkg::in_item_t item_q;
	logic first_q;
	logic signed [16:0] err_q;
	logic signed [33:0] p_q;
	logic signed [33:0] kierr_q;
	logic signed [49:0] inc_q;
	logic signed [31:0] dent_q;
	logic signed [31:0] rd_q;
	logic rd_vld_q;
	logic signed [39:0] sum_q;
	logic [1:0] part_q;
	logic [75:0] recip_acc_q;
	logic signed [31:0] mean_q;

	pidad_pkg::div_ctl_t div_ctl;
	logic [47:0] div_num;
	logic div_done;
	logic signed [48:0] div_quo;

	logic signed [16:0] delta;
	logic signed [33:0] kd_delta;
	logic signed [31:0] hi_lim, lo_lim;

	assign hi_lim = {max_q, 16'h0};
	assign lo_lim = {min_q, 16'h0};
	assign delta  = 17'(item_q.measurement) - 17'(prev_q);
	assign kd_delta = $signed({18'b0, kd_q}) * 34'(delta);
	assign div_num  = kd_delta[33] ? 48'(-kd_delta) << 16 : 48'(kd_delta) << 16;
	assign div_ctl.start = (state_q == ST_MUL) && !first_q && (item_q.elapsed != 16'd0);
	assign div_ctl.neg   = kd_delta[33];

	pidad_div u_div (
		.clk(clk), .arst_n(arst_n), .ctl(div_ctl),
		.dividend(div_num), .divisor(item_q.elapsed),
		.done(div_done), .quotient(div_quo)
	);

	function automatic logic signed [31:0] clamp(input logic signed [49:0] v,
		input logic signed [31:0] hi, input logic signed [31:0] lo);
		if (v > 50'(hi)) return hi;
		if (v < 50'(lo)) return lo;
		return 32'(v);
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
		if (v > 50'sh7fffffff) return 32'sh7fffffff;
		if (v < -50'sh80000000) return 32'sh80000000;
		return 32'(v);
	endfunction

	logic signed [49:0] integ_sum;
	logic signed [49:0] neg_q;
	logic [39:0] sum_mag;
	logic [15:0] recip_part;
	logic [55:0] part_prod;
	logic [31:0] q_mag;

	assign integ_sum = 50'(integ_q) + (inc_q >>> 16);
	assign neg_q = -50'(div_quo);
	// truncating mean: magnitude times the reciprocal, 16 bits of it per cycle
	assign sum_mag = sum_q[39] ? 40'(-sum_q) : 40'(sum_q);
	assign recip_part = (part_q == 2'd0) ? Recip[15:0] :
		(part_q == 2'd1) ? Recip[31:16] : Recip[47:32];
	assign part_prod = sum_mag * recip_part;
	assign q_mag = recip_acc_q[75:44];

	assign in_stall = (state_q != ST_IDLE);

	// control sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			kp_q       <= pidad_pkg::KP_RESET;
			ki_q       <= pidad_pkg::KI_RESET;
			kd_q       <= pidad_pkg::KD_RESET;
			max_q      <= pidad_pkg::MAX_RESET;
			min_q      <= pidad_pkg::MIN_RESET;
			started_q  <= 1'b0;
			slot_q     <= '0;
			ring_vld_q <= '0;
			out_valid  <= 1'b0;
			prev_q     <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					pidad_pkg::REG_KP:  kp_q  <= cfg_data;
					pidad_pkg::REG_KI:  ki_q  <= cfg_data;
					pidad_pkg::REG_KD:  kd_q  <= cfg_data;
					pidad_pkg::REG_MAX: max_q <= cfg_data;
					pidad_pkg::REG_MIN: min_q <= cfg_data;
					default: ;
				endcase
			end
			unique case (state_q)
				ST_IDLE: if (in_valid) state_q <= ST_MUL;
				ST_MUL: begin
					if (div_ctl.start) state_q <= ST_DIV;
					else state_q <= ST_SUM;
				end
				ST_DIV: if (div_done) state_q <= ST_SUM;
				ST_SUM: if (idx_q == LastSlot) state_q <= ST_ACC;
				ST_ACC: state_q <= ST_MEAN;
				ST_MEAN: if (part_q == 2'd3) state_q <= ST_FIN;
				ST_FIN: begin
					ring_vld_q[slot_q] <= 1'b1;
					slot_q    <= (slot_q == LastSlot) ? '0 : slot_q + 1'b1;
					started_q <= 1'b1;
					prev_q    <= item_q.measurement;
					out_valid <= 1'b1;
					state_q   <= ST_OUT;
				end
				ST_OUT: if (!out_stall) begin
					out_valid <= 1'b0;
					state_q   <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				item_q   <= in_data;
				first_q  <= !started_q;
				err_q    <= 17'(in_data.target) - 17'(in_data.measurement);
				idx_q    <= '0;
				dent_q   <= '0;
				sum_q    <= '0;
				rd_vld_q <= 1'b0;
			end
			ST_MUL: begin
				p_q     <= $signed({18'b0, kp_q}) * 34'(err_q);
				kierr_q <= $signed({1'b0, ki_q}) * err_q;
			end
			ST_DIV: if (div_done) dent_q <= sat32(neg_q);
			ST_SUM: begin
				// new entry goes in first; reads are registered, one entry per cycle
				if (idx_q == '0) begin
					ring_q[slot_q] <= dent_q;
					inc_q <= kierr_q * $signed({1'b0, item_q.elapsed});
				end
				if (idx_q == slot_q) rd_q <= dent_q;
				else if (ring_vld_q[idx_q]) rd_q <= ring_q[idx_q];
				else rd_q <= '0;
				rd_vld_q <= 1'b1;
				if (rd_vld_q) sum_q <= sum_q + 40'(rd_q);
				idx_q <= (idx_q == LastSlot) ? idx_q : idx_q + 1'b1;
			end
			ST_ACC: begin
				sum_q <= sum_q + 40'(rd_q);
				if (first_q) integ_q <= clamp(50'(hi_lim), hi_lim, lo_lim);
				else integ_q <= clamp(integ_sum, hi_lim, lo_lim);
				recip_acc_q <= '0;
				part_q      <= '0;
			end
			ST_MEAN: begin
				if (part_q == 2'd3) mean_q <= sum_q[39] ? -q_mag : q_mag;
				else recip_acc_q <= recip_acc_q + (76'(part_prod) << {part_q, 4'b0000});
				part_q <= part_q + 2'd1;
			end
			ST_FIN: begin
				out_data.p_term <= sat32(50'(p_q));
				out_data.i_term <= integ_q;
				out_data.d_term <= mean_q;
				out_data.drive  <= clamp(50'(sat32(50'(p_q))) + 50'(integ_q) + 50'(mean_q),
					hi_lim, lo_lim);
			end
			default: ;
		endcase
	end

`ifndef SYNTHESIS
	a_stall_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall) else $error("accepting while result pending");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid) else $error("result dropped");
	a_started: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> started_q) else $error("start flag not set");
`endif

endmodule
